// File: hdl/spim_pkg.sv
// ----------------------------------------------------------------------------
// spim_pkg: shared types and constants for the SPI mode 0 byte master
// Word layouts, the half period table and register codes.
// ----------------------------------------------------------------------------
package spim_pkg;

    localparam int HALF_W = 10;

    localparam logic [7:0] TX_IDLE_BYTE = 8'hFF;

    // Register index (byte address / 4)
    localparam logic REG_SPEED_SELECT = 1'b0;

    // Item kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic       tx_present;
        logic       miso_level;
        logic       last_in_burst;
    } item_t;

    typedef struct packed {
        logic       sck;
        logic       mosi;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       burst_end;
        logic       rejected;
    } result_t;

    // Half period in one-microsecond ticks
    function automatic logic [HALF_W-1:0] half_period(input logic [7:0] sel);
        logic [HALF_W-1:0] hp;
        unique case (sel)
            8'd1:    hp = 10'd1000;
            8'd2:    hp = 10'd500;
            8'd3:    hp = 10'd250;
            8'd4:    hp = 10'd125;
            8'd5:    hp = 10'd62;
            8'd6:    hp = 10'd31;
            8'd7:    hp = 10'd15;
            8'd8:    hp = 10'd5;
            default: hp = 10'd5;
        endcase
        return hp;
    endfunction

endpackage

// File: hdl/spim_cfg.sv
// ----------------------------------------------------------------------------
// spim_cfg: configuration register file
// Holds speed_select and decodes it to the half period length.
// ----------------------------------------------------------------------------
module spim_cfg import spim_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [HALF_W-1:0] half_len
);

    logic [7:0] speed_sel_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_SPEED_SELECT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_sel_reg <= 8'd0;
        end else if (wr_en) begin
            speed_sel_reg <= pwdata[7:0];
        end
    end

    assign prdata   = (paddr[2] == REG_SPEED_SELECT) ? {24'd0, speed_sel_reg} : 32'd0;
    assign half_len = half_period(speed_sel_reg);

endmodule

// File: hdl/spim_core.sv
// ----------------------------------------------------------------------------
// spim_core: SPI bit engine
// Pin state, shift registers and half period counter; one word per step.
// ----------------------------------------------------------------------------
module spim_core import spim_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  item_t             item,
    input  logic [HALF_W-1:0] half_len,
    output result_t           result
);

    logic              clk_lvl_reg,  clk_lvl_next;
    logic              dout_reg,     dout_next;
    logic [7:0]        tx_sh_reg,    tx_sh_next;
    logic [7:0]        rx_sh_reg,    rx_sh_next;
    logic [2:0]        bit_pos_reg,  bit_pos_next;
    logic [HALF_W-1:0] ticks_reg,    ticks_next;
    logic              active_reg,   active_next;
    logic              burst_reg,    burst_next;
    logic [HALF_W-1:0] ticks_dec;
    logic [7:0]        load_byte;
    result_t           result_reg,   result_next;

    always_comb begin
        clk_lvl_next = clk_lvl_reg;
        dout_next    = dout_reg;
        tx_sh_next   = tx_sh_reg;
        rx_sh_next   = rx_sh_reg;
        bit_pos_next = bit_pos_reg;
        ticks_next   = ticks_reg;
        active_next  = active_reg;
        burst_next   = burst_reg;
        result_next  = '0;
        load_byte    = item.tx_present ? item.tx_byte : TX_IDLE_BYTE;
        ticks_dec    = (ticks_reg != '0) ? ticks_reg - 1'b1 : ticks_reg;

        if (item.kind == KIND_START) begin
            if (active_reg) begin
                result_next.rejected = 1'b1;
            end else begin
                tx_sh_next   = load_byte;
                rx_sh_next   = 8'd0;
                bit_pos_next = 3'd7;
                clk_lvl_next = 1'b0;
                dout_next    = load_byte[7];
                ticks_next   = half_len;
                active_next  = 1'b1;
                burst_next   = item.last_in_burst;
            end
        end else if (active_reg) begin
            ticks_next = ticks_dec;
            if (ticks_dec == '0) begin
                if (!clk_lvl_reg) begin
                    // rising edge: sample MISO
                    clk_lvl_next = 1'b1;
                    rx_sh_next   = {rx_sh_reg[6:0], item.miso_level};
                    ticks_next   = half_len;
                end else begin
                    clk_lvl_next = 1'b0;
                    if (bit_pos_reg == 3'd0) begin
                        active_next           = 1'b0;
                        result_next.done_res  = 1'b1;
                        result_next.rx_byte   = rx_sh_reg;
                        result_next.burst_end = burst_reg;
                    end else begin
                        // falling edge: shift out the next bit
                        bit_pos_next = bit_pos_reg - 3'd1;
                        tx_sh_next   = {tx_sh_reg[6:0], 1'b0};
                        dout_next    = tx_sh_reg[6];
                        ticks_next   = half_len;
                    end
                end
            end
        end

        result_next.sck      = clk_lvl_next;
        result_next.mosi     = dout_next;
        result_next.busy_res = active_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clk_lvl_reg <= 1'b0;
            dout_reg    <= 1'b0;
            tx_sh_reg   <= 8'd0;
            rx_sh_reg   <= 8'd0;
            bit_pos_reg <= 3'd0;
            ticks_reg   <= '0;
            active_reg  <= 1'b0;
            burst_reg   <= 1'b0;
        end else if (step) begin
            clk_lvl_reg <= clk_lvl_next;
            dout_reg    <= dout_next;
            tx_sh_reg   <= tx_sh_next;
            rx_sh_reg   <= rx_sh_next;
            bit_pos_reg <= bit_pos_next;
            ticks_reg   <= ticks_next;
            active_reg  <= active_next;
            burst_reg   <= burst_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// File: hdl/spi_mode0_master_byte.sv
// Each accepted word is held in the input register, then in the result register.
// Throughput: one word per cycle unless m_tready stalls the result; every input word
// yields exactly one result word. The input register can take one more word while
// the result side stalls; the SPI state updates once per word in a single pass.
// Reset: synchronous, active low on aresetn; clears the pins, the transfer state,
// speed_select and both valid flags.
// ----------------------------------------------------------------------------
// spi_mode0_master_byte: SPI mode 0 byte master driven by tick words
// Ticks of one microsecond advance SCK/MOSI; start words load a byte to send.
// ----------------------------------------------------------------------------
module spi_mode0_master_byte import spim_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] tx_byte, [8] tx_present, [9] miso_level, rest 0
    input  logic        s_tuser,   // [0] kind
    input  logic        s_tlast,   // last_in_burst
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] sck, [1] mosi, [2] busy_res, [3] done_res,
                                   // [11:4] rx_byte, [12] rejected, rest 0
    output logic        m_tlast,   // burst_end
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic              in_valid_reg;
    item_t             in_item_reg;
    logic              out_valid_reg;
    logic              step;
    logic [HALF_W-1:0] half_len;
    result_t           result;

    // Advance the held word when the result register is free or being drained
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (step) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the payload; no reset needed
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.kind          <= s_tuser;
            in_item_reg.tx_byte       <= s_tdata[7:0];
            in_item_reg.tx_present    <= s_tdata[8];
            in_item_reg.miso_level    <= s_tdata[9];
            in_item_reg.last_in_burst <= s_tlast;
        end
    end

    spim_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .half_len (half_len)
    );

    spim_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .item     (in_item_reg),
        .half_len (half_len),
        .result   (result)
    );

    // Pack the result word
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, result.rejected, result.rx_byte, result.done_res,
                       result.busy_res, result.mosi, result.sck};
    assign m_tlast  = result.burst_end;

endmodule

// File: hdl/spim_checker.sv
// ----------------------------------------------------------------------------
// spim_checker: port-level checks for the SPI byte master
// Watches the result channel for consistent transfer status.
// ----------------------------------------------------------------------------
module spim_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // A completed byte ends the transfer with SCK low
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> !m_tdata[2] && !m_tdata[0])
        else $error("done word shows busy or SCK high");

    // A rejected start leaves the running transfer in progress
    a_reject_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[12] |-> m_tdata[2] && !m_tdata[3])
        else $error("rejected start without a running transfer");

    // Received byte and burst end only show on completion
    a_rx_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[3] |-> m_tdata[11:4] == 8'd0 && !m_tlast)
        else $error("rx_byte or burst_end set without done");

    // A stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

endmodule

bind spi_mode0_master_byte spim_checker u_spim_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for spi_mode0_master_byte
// Streams tick and start words into the SPI master, predicts every result
// word from a cycle-free model of the pin state machine, and compares the
// result stream field by field under random idling and back-pressure.
// ----------------------------------------------------------------------------
module testbench;
    import spim_pkg::*;

    // Receiver hold-off length and the no-progress limit of the watchdog
    localparam int HOLD_CYCLES = 300;
    localparam int STUCK_LIMIT = 4000;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;    // [7:0] tx_byte, [8] tx_present, [9] miso_level, rest 0
    logic        s_tuser  = 1'b0;  // [0] kind
    logic        s_tlast  = 1'b0;  // last_in_burst
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // [0] sck, [1] mosi, [2] busy_res, [3] done_res,
                                   // [11:4] rx_byte, [12] rejected, rest 0
    logic        m_tlast;          // burst_end
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    spi_mode0_master_byte dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Words waiting to be offered, and pin results still owed by the block
    item_t   pending_words[$];
    result_t expected_results[$];
    int      words_queued = 0;
    int      mismatches   = 0;

    // Idle percentages for each side, changed per phase by the stimulus
    int sender_idle_pct   = 36;
    int receiver_idle_pct = 85;

    // Long receiver hold-off: stimulus bumps the request count, monitor serves it
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    int stuck_cycles = 0;

    // ------------------------------------------------------------------
    // Pin-level model of the master: its own copy of register and state
    // ------------------------------------------------------------------
    logic [7:0] speed_q   = '0;
    logic       sck_q     = 1'b0;
    logic       mosi_q    = 1'b0;
    logic [7:0] shift_out = '0;
    logic [7:0] shift_in  = '0;
    logic [2:0] bit_idx   = '0;
    logic [9:0] half_left = '0;
    logic       xfer_on   = 1'b0;
    logic       burst_q   = 1'b0;

    // Half period in ticks for a speed select value; out-of-table values run fastest
    function automatic logic [9:0] half_len_of(input logic [7:0] sel);
        case (sel)
            8'd1:    return 10'd1000;
            8'd2:    return 10'd500;
            8'd3:    return 10'd250;
            8'd4:    return 10'd125;
            8'd5:    return 10'd62;
            8'd6:    return 10'd31;
            8'd7:    return 10'd15;
            default: return 10'd5;
        endcase
    endfunction

    // Apply one accepted word to the model and return the pins it leaves behind
    function automatic result_t advance_spi(input item_t w);
        result_t r;
        r = '0;
        if (w.kind == KIND_START) begin
            if (xfer_on) begin
                // a start during a transfer is dropped and flagged
                r.rejected = 1'b1;
            end else begin
                shift_out = w.tx_present ? w.tx_byte : TX_IDLE_BYTE;
                shift_in  = '0;
                bit_idx   = 3'd7;
                sck_q     = 1'b0;
                mosi_q    = shift_out[7];
                half_left = half_len_of(speed_q);
                xfer_on   = 1'b1;
                burst_q   = w.last_in_burst;
            end
        end else if (xfer_on) begin
            if (half_left != 0)
                half_left = half_left - 10'd1;
            if (half_left == 0) begin
                if (!sck_q) begin
                    // rising edge: sample MISO
                    sck_q     = 1'b1;
                    shift_in  = {shift_in[6:0], w.miso_level};
                    half_left = half_len_of(speed_q);
                end else begin
                    // falling edge: finish the byte or present the next bit
                    sck_q = 1'b0;
                    if (bit_idx == 0) begin
                        xfer_on     = 1'b0;
                        r.done_res  = 1'b1;
                        r.rx_byte   = shift_in;
                        r.burst_end = burst_q;
                    end else begin
                        bit_idx   = bit_idx - 3'd1;
                        shift_out = shift_out << 1;
                        mosi_q    = shift_out[7];
                        half_left = half_len_of(speed_q);
                    end
                end
            end
        end
        // an idle tick leaves every pin as it was
        r.sck      = sck_q;
        r.mosi     = mosi_q;
        r.busy_res = xfer_on;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer queued words, hold a word until it is taken, predict on accept
    // ------------------------------------------------------------------
    item_t word_on_bus;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(advance_spi(word_on_bus));
            // pick a new word only once the current one is gone
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() != 0 &&
                    $urandom_range(0, 99) >= sender_idle_pct) begin
                    word_on_bus = pending_words.pop_front();
                    s_tdata  <= {6'b0, word_on_bus.miso_level, word_on_bus.tx_present,
                                 word_on_bus.tx_byte};
                    s_tuser  <= word_on_bus.kind;
                    s_tlast  <= word_on_bus.last_in_burst;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted result word against the oldest prediction
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.sck       = m_tdata[0];
                got.mosi      = m_tdata[1];
                got.busy_res  = m_tdata[2];
                got.done_res  = m_tdata[3];
                got.rx_byte   = m_tdata[11:4];
                got.rejected  = m_tdata[12];
                got.burst_end = m_tlast;
                if (expected_results.size() == 0) begin
                    $error("result word arrived with no prediction pending");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("sck",       want.sck,       got.sck);
                    check_field("mosi",      want.mosi,      got.mosi);
                    check_field("busy_res",  want.busy_res,  got.busy_res);
                    check_field("done_res",  want.done_res,  got.done_res);
                    check_field("rx_byte",   want.rx_byte,   got.rx_byte);
                    check_field("burst_end", want.burst_end, got.burst_end);
                    check_field("rejected",  want.rejected,  got.rejected);
                end
            end
            // serve a pending hold-off request, then count it down
            if (hold_served != hold_requests) begin
                hold_left   = HOLD_CYCLES;
                hold_served = hold_requests;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when work is outstanding but nothing moves
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (pending_words.size() == 0 && !s_tvalid && expected_results.size() == 0)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == STUCK_LIMIT) begin
            $display("spi_mode0_master_byte verification failed");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_word(input logic kind, input logic [7:0] tx, input logic present,
                             input logic miso, input logic last);
        item_t w;
        w.kind          = kind;
        w.tx_byte       = tx;
        w.tx_present    = present;
        w.miso_level    = miso;
        w.last_in_burst = last;
        pending_words.push_back(w);
        words_queued++;
    endtask

    // Random content in every field; only the kind is chosen
    task automatic push_noise(input logic kind);
        push_word(kind, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // Ticks with a fixed MISO level, or a random one when use_fixed is clear
    task automatic push_ticks(input int n, input bit use_fixed, input logic level);
        repeat (n) begin
            push_word(KIND_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      use_fixed ? level : 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        end
    endtask

    // One byte transfer: a start, enough ticks to finish it (or fewer when cut short),
    // stray starts sprinkled in to hit the busy case, and a few idle ticks after
    task automatic push_transfer(input int half_len, input bit cut_short);
        int n_ticks;
        n_ticks = 16 * half_len;
        if (cut_short)
            n_ticks = $urandom_range(1, n_ticks - 1);
        push_word(KIND_START, 8'($urandom_range(0, 255)), $urandom_range(0, 4) != 0,
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        for (int i = 0; i < n_ticks; i++) begin
            if ($urandom_range(0, 99) < 2)
                push_noise(KIND_START);
            push_ticks(1, 1'b0, 1'b0);
        end
        push_ticks($urandom_range(0, 3), 1'b0, 1'b0);
    endtask

    // Mostly well-formed transfers, some cut short, some bursts of noise
    task automatic run_random(input int half_len, input int n_words);
        int stop_at;
        int pick;
        stop_at = words_queued + n_words;
        while (words_queued < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                repeat ($urandom_range(1, 6)) push_noise(1'($urandom_range(0, 1)));
            else
                push_transfer(half_len, pick < 20);
        end
    endtask

    // Let every queued word go through and every result come back
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (pending_words.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Tick in small batches until no transfer is running
    task automatic finish_transfer();
        while (xfer_on) begin
            push_ticks(16, 1'b0, 1'b0);
            wait_drained();
        end
    endtask

    // APB write of speed_select: setup cycle, then access cycle
    task automatic set_speed(input logic [7:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 3'(REG_SPEED_SELECT) << 2;
        pwdata  <= {24'h0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        speed_q = value;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words at the reset speed (unconfigured select, fastest half period)
        push_word(KIND_TICK, 8'hFF, 1'b1, 1'b1, 1'b1);      // tick while idle
        push_word(KIND_START, 8'h00, 1'b1, 1'b0, 1'b1);     // all-zero byte, burst end
        push_word(KIND_START, 8'h5A, 1'b1, 1'b1, 1'b0);     // start while busy
        push_ticks(80, 1'b1, 1'b1);                         // MISO high: receive 0xFF
        push_word(KIND_TICK, 8'h00, 1'b0, 1'b0, 1'b0);      // idle tick keeps the pins
        push_word(KIND_START, 8'h00, 1'b0, 1'b1, 1'b0);     // no byte given: sends 0xFF
        push_ticks(80, 1'b1, 1'b0);                         // MISO low: receive 0x00
        push_word(KIND_START, 8'hA5, 1'b1, 1'b0, 1'b1);
        push_ticks(80, 1'b0, 1'b0);
        push_word(KIND_START, 8'hFF, 1'b1, 1'b0, 1'b0);
        push_ticks(40, 1'b0, 1'b0);
        push_word(KIND_START, 8'h3C, 1'b0, 1'b1, 1'b1);     // rejected mid-byte
        push_ticks(40, 1'b0, 1'b0);
        push_word(KIND_START, 8'h80, 1'b1, 1'b1, 1'b0);     // right after completion
        push_ticks(80, 1'b0, 1'b0);
        wait_drained();

        set_speed(8'd8);
        run_random(5, 80);
        wait_drained();

        // Swap the idling sides
        sender_idle_pct   = 85;
        receiver_idle_pct = 36;
        set_speed(8'd255);
        // hold the receiver off while the sender keeps offering
        @(negedge aclk);
        hold_requests++;
        run_random(5, 50);
        // pause the sender until the block has emptied, then continue
        wait_drained();
        run_random(5, 50);
        wait_drained();

        set_speed(8'd9);
        run_random(5, 40);
        wait_drained();

        set_speed(8'd7);
        run_random(15, 40);
        wait_drained();

        // No idling on either side
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        set_speed(8'd0);
        run_random(5, 60);
        wait_drained();
        finish_transfer();

        // Slow speed: run past the first rising edge, then finish fast
        set_speed(8'd6);
        push_word(KIND_START, 8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b1);
        push_ticks(34, 1'b0, 1'b0);
        wait_drained();
        set_speed(8'd8);
        finish_transfer();

        // Speed change inside a half period only takes effect at the next edge
        set_speed(8'd5);
        push_word(KIND_START, 8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0);
        push_ticks(66, 1'b0, 1'b0);
        wait_drained();
        set_speed(8'd1);
        push_ticks(70, 1'b0, 1'b0);
        wait_drained();

        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("spi_mode0_master_byte verification clean");
        end else begin
            $display("spi_mode0_master_byte verification failed");
        end
        $finish;
    end

endmodule
